>>> rtl/core/lpr_pkg.sv
package lpr_pkg;

   localparam int RING_DEPTH_DEF    = 2048;
   localparam int LONG_LAG_DEF      = 1279;
   localparam int SHORT_LAG_DEF     = 418;
   localparam int SHUFFLE_DEPTH_DEF = 32;

   localparam logic [30:0] LCG1_MOD  = 31'd2147483563;
   localparam logic [30:0] LCG2_MOD  = 31'd2147483399;
   localparam logic [15:0] LCG1_MULT = 16'd40014;
   localparam logic [15:0] LCG2_MULT = 16'd40692;
   // 2^31 minus the modulus, used to fold the high half back in
   localparam logic [7:0]  LCG1_FOLD = 8'd85;
   localparam logic [7:0]  LCG2_FOLD = 8'd249;
   localparam logic [30:0] RAW_FULL  = 31'd2147483647;

   typedef enum logic {
      OP_GENERATE,
      OP_RESEED
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WRITE,
      ST_SCALE,
      ST_OUT,
      ST_RESEED
   } top_state_type;

   typedef enum logic [2:0] {
      SD_IDLE,
      SD_WARM_MUL,
      SD_WARM_RED,
      SD_DRAW_MUL,
      SD_DRAW_IDX,
      SD_DRAW_SEL,
      SD_WORD
   } seed_state_type;

   typedef struct packed {
      logic        start;
      logic [30:0] seed;
   } seed_ctrl_type;

   typedef struct packed {
      logic done;
      logic wr_en;
   } seed_stat_type;

   // a*x mod m for m = 2^31 - fold, given the 47-bit product a*x
   function automatic logic [30:0] lcg_reduce(input logic [46:0] prod,
                                              input logic [7:0]  fold,
                                              input logic [30:0] modulus);
      logic [23:0] hc;
      logic [31:0] v;
      hc = 24'(prod[46:31]) * 24'(fold);
      v  = 32'(hc) + 32'(prod[30:0]);
      if (v >= 32'(modulus)) begin
         v = v - 32'(modulus);
      end
      return v[30:0];
   endfunction

endpackage

>>> rtl/core/lpr_ring_ram.sv
module lpr_ring_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr_a,
   input  logic [AW-1:0] raddr_b,
   output logic [31:0]   rdata_a,
   output logic [31:0]   rdata_b
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

>>> rtl/core/lpr_seeder.sv
module lpr_seeder
   import lpr_pkg::*;
#(
   parameter int RING_DEPTH    = RING_DEPTH_DEF,
   parameter int SHUFFLE_DEPTH = SHUFFLE_DEPTH_DEF,
   parameter int AW            = $clog2(RING_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  seed_ctrl_type ctrl,
   output seed_stat_type stat,
   output logic [AW-1:0] wr_addr,
   output logic [31:0]   wr_data
);

   localparam int IW = $clog2(SHUFFLE_DEPTH);
   localparam int EW = IW + 1;
   localparam int CW = $clog2(SHUFFLE_DEPTH + 8);
   localparam logic [39:0] SPREAD = 40'(1 + (2147483562 / SHUFFLE_DEPTH));

   seed_state_type state_ff, state_in;
   logic [30:0]    first_ff, first_in;
   logic [30:0]    second_ff, second_in;
   logic [30:0]    out_ff, out_in;
   logic [46:0]    prod1_ff, prod1_in;
   logic [46:0]    prod2_ff, prod2_in;
   logic [EW-1:0]  est_ff, est_in;
   logic [IW-1:0]  j_ff, j_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [4:0]     bit_ff, bit_in;
   logic [30:0]    word_ff, word_in;
   logic [AW-1:0]  waddr_ff, waddr_in;
   logic [30:0]    table_ff [SHUFFLE_DEPTH];

   logic           tbl_we;
   logic [IW-1:0]  tbl_addr;
   logic [30:0]    tbl_data;

   logic [30:0]    red1, red2;
   logic [30+EW:0] est_prod;
   logic [39:0]    thr;
   logic [EW-1:0]  jsum;
   logic [32:0]    diff;
   logic [32:0]    outn;
   logic           draw;

   assign red1     = lcg_reduce(prod1_ff, LCG1_FOLD, LCG1_MOD);
   assign red2     = lcg_reduce(prod2_ff, LCG2_FOLD, LCG2_MOD);
   assign est_prod = (31 + EW)'(out_ff) * (31 + EW)'(SHUFFLE_DEPTH);
   assign thr      = 40'(est_ff + EW'(1)) * SPREAD;
   assign jsum     = est_ff + EW'(40'(out_ff) >= thr);
   assign diff     = {2'b0, table_ff[j_ff]} - {2'b0, second_ff};
   assign outn     = $signed(diff) < 33'sd1 ? diff + 33'(LCG1_MOD - 31'd1) : diff;
   assign draw     = {outn[31:0], 1'b0} > 33'(LCG1_MOD);
   assign wr_addr  = waddr_ff;
   assign wr_data  = {word_ff, 1'b1};

   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      second_in = second_ff;
      out_in    = out_ff;
      prod1_in  = prod1_ff;
      prod2_in  = prod2_ff;
      est_in    = est_ff;
      j_in      = j_ff;
      cnt_in    = cnt_ff;
      bit_in    = bit_ff;
      word_in   = word_ff;
      waddr_in  = waddr_ff;
      tbl_we    = 1'b0;
      tbl_addr  = j_ff;
      tbl_data  = first_ff;
      stat      = '0;
      unique case (state_ff)
         SD_IDLE: begin
            if (ctrl.start) begin
               first_in  = (ctrl.seed == 31'd0) ? 31'd1 : ctrl.seed;
               second_in = (ctrl.seed == 31'd0) ? 31'd1 : ctrl.seed;
               cnt_in    = CW'(SHUFFLE_DEPTH + 7);
               state_in  = SD_WARM_MUL;
            end
         end
         SD_WARM_MUL: begin
            prod1_in = 47'(first_ff) * 47'(LCG1_MULT);
            state_in = SD_WARM_RED;
         end
         SD_WARM_RED: begin
            first_in = red1;
            if (cnt_ff < CW'(SHUFFLE_DEPTH)) begin
               tbl_we   = 1'b1;
               tbl_addr = cnt_ff[IW-1:0];
               tbl_data = red1;
            end
            if (cnt_ff == '0) begin
               out_in   = red1;
               bit_in   = '0;
               waddr_in = '0;
               state_in = SD_DRAW_MUL;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = SD_WARM_MUL;
            end
         end
         SD_DRAW_MUL: begin
            prod1_in = 47'(first_ff) * 47'(LCG1_MULT);
            prod2_in = 47'(second_ff) * 47'(LCG2_MULT);
            est_in   = est_prod[30+EW:31];
            state_in = SD_DRAW_IDX;
         end
         SD_DRAW_IDX: begin
            first_in  = red1;
            second_in = red2;
            // estimate is at most one low; saturate to the last entry
            if (jsum > EW'(SHUFFLE_DEPTH - 1)) begin
               j_in = IW'(SHUFFLE_DEPTH - 1);
            end else begin
               j_in = jsum[IW-1:0];
            end
            state_in = SD_DRAW_SEL;
         end
         SD_DRAW_SEL: begin
            tbl_we = 1'b1;
            out_in = outn[30:0];
            if (bit_ff != 5'd31) begin
               word_in[bit_ff] = draw;
               bit_in          = bit_ff + 5'd1;
               state_in        = SD_DRAW_MUL;
            end else begin
               state_in = SD_WORD;
            end
         end
         SD_WORD: begin
            stat.wr_en = 1'b1;
            bit_in     = '0;
            if (waddr_ff == AW'(RING_DEPTH - 1)) begin
               stat.done = 1'b1;
               state_in  = SD_IDLE;
            end else begin
               waddr_in = waddr_ff + AW'(1);
               state_in = SD_DRAW_MUL;
            end
         end
         default: state_in = SD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      out_ff    <= out_in;
      prod1_ff  <= prod1_in;
      prod2_ff  <= prod2_in;
      est_ff    <= est_in;
      j_ff      <= j_in;
      cnt_ff    <= cnt_in;
      bit_ff    <= bit_in;
      word_ff   <= word_in;
      waddr_ff  <= waddr_in;
      if (tbl_we) begin
         table_ff[tbl_addr] <= tbl_data;
      end
   end

endmodule

>>> rtl/core/lpr_scaler.sv
module lpr_scaler
   import lpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] raw,
   input  logic [31:0] range_min,
   input  logic [31:0] range_max,
   output logic        done,
   output logic [31:0] result
);

   logic [4:0]  vld_ff, vld_in;
   logic [30:0] raw_ff, raw_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic        rev_ff, rev_in;
   logic [32:0] span_ff, span_in;
   logic [62:0] prod_ff, prod_in;
   logic [31:0] h_ff, h_in;
   logic [32:0] t_ff, t_in;
   logic [32:0] q_ff, q_in;
   logic [31:0] res_ff, res_in;

   logic [33:0] span_w;
   logic [31:0] u;
   logic [33:0] val;

   assign span_w = {{2{range_max[31]}}, range_max} - {{2{range_min[31]}}, range_min} + 34'd1;
   assign u      = 32'(t_ff[30:0]) + 32'(t_ff[32:31]);
   assign val    = {{2{lo_ff[31]}}, lo_ff} + {1'b0, q_ff};
   assign done   = vld_ff[4];
   assign result = res_ff;

   always_comb begin
      vld_in  = {vld_ff[3:0], start};
      raw_in  = raw_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      rev_in  = rev_ff;
      span_in = span_ff;
      if (start) begin
         raw_in  = raw;
         lo_in   = range_min;
         hi_in   = range_max;
         rev_in  = $signed(range_max) < $signed(range_min);
         span_in = span_w[32:0];
      end
      // a span of 2^32 has a zero low word, so the top bit ors in
      prod_in = (63'(raw_ff) * 63'(span_ff[31:0])) |
                (span_ff[32] ? {raw_ff, 32'b0} : 63'b0);
      // divide by 2^31-1 using 2^31 = 1 modulo the divisor
      h_in    = prod_ff[62:31];
      t_in    = 33'(prod_ff[62:31]) + 33'(prod_ff[30:0]);
      q_in    = 33'(h_ff) + 33'(t_ff[32:31]) + 33'(u >= 32'(RAW_FULL));
      if (rev_ff) begin
         res_in = lo_ff;
      end else if ($signed(val) > $signed({{2{hi_ff[31]}}, hi_ff})) begin
         res_in = hi_ff;
      end else begin
         res_in = val[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      raw_ff  <= raw_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rev_ff  <= rev_in;
      span_ff <= span_in;
      prod_ff <= prod_in;
      h_ff    <= h_in;
      t_ff    <= t_in;
      q_ff    <= q_in;
      if (vld_ff[3]) begin
         res_ff <= res_in;
      end
   end

endmodule

>>> rtl/core/lagged_product_random_generator_top.sv
// Lagged product random generator.
// Requests come in on req_valid/req_ready with req_opcode, req_seed,
// req_range_min and req_range_max. A generate request returns one result on
// rsp_valid/rsp_ready (rsp_raw_value, rsp_ranged_value); a reseed request
// returns nothing and refills the whole ring from the seed.
// One request is worked on at a time. A generate passes through ring read,
// product, write back, then the five-stage scaler before rsp_valid; the next
// request can be taken as soon as the result is on rsp_valid. A reseed warms
// up the seeder's shuffle table, then runs the seeder's draw loop
// (SD_DRAW_MUL, SD_DRAW_IDX, SD_DRAW_SEL), 32 draws per ring word.
// After reset the ring is cleared to zero, one word a cycle, through all
// RING_DEPTH words; req_ready stays low until then.
// The result sits in an output register: a new request is accepted while it
// waits, and a finished generate holds until rsp_ready frees the register.
module lagged_product_random_generator_top
   import lpr_pkg::*;
#(
   parameter int RING_DEPTH    = RING_DEPTH_DEF,
   parameter int LONG_LAG      = LONG_LAG_DEF,
   parameter int SHORT_LAG     = SHORT_LAG_DEF,
   parameter int SHUFFLE_DEPTH = SHUFFLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [30:0] req_seed,
   input  logic [31:0] req_range_min,
   input  logic [31:0] req_range_max,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_raw_value,
   output logic [31:0] rsp_ranged_value
);

   localparam int AW = $clog2(RING_DEPTH);

   top_state_type state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0]   prod_ff, prod_in;
   logic [31:0]   lo_ff, lo_in;
   logic [31:0]   hi_ff, hi_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [30:0]   rsp_raw_ff, rsp_raw_in;
   logic [31:0]   rsp_ranged_ff, rsp_ranged_in;

   logic [AW-1:0] p_next, addr_a, addr_b;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata, rd_a, rd_b;
   logic          scl_start, scl_done;
   logic [31:0]   scl_result;
   seed_ctrl_type seed_ctrl;
   seed_stat_type seed_stat;
   logic [AW-1:0] seed_addr;
   logic [31:0]   seed_data;

   assign p_next = (ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
   assign addr_a = (p_next >= AW'(LONG_LAG)) ? p_next - AW'(LONG_LAG)
                 : AW'((AW + 1)'(p_next) + (AW + 1)'(RING_DEPTH - LONG_LAG));
   assign addr_b = (p_next >= AW'(SHORT_LAG)) ? p_next - AW'(SHORT_LAG)
                 : AW'((AW + 1)'(p_next) + (AW + 1)'(RING_DEPTH - SHORT_LAG));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_ranged_value = rsp_ranged_ff;

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      clr_in         = clr_ff;
      prod_in        = prod_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_raw_in     = rsp_raw_ff;
      rsp_ranged_in  = rsp_ranged_ff;
      req_ready      = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = ptr_ff;
      mem_wdata      = prod_ff;
      scl_start      = 1'b0;
      seed_ctrl.start = 1'b0;
      seed_ctrl.seed  = req_seed;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AW'(RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_RESEED) begin
                  seed_ctrl.start = 1'b1;
                  state_in        = ST_RESEED;
               end else begin
                  mem_re   = 1'b1;
                  ptr_in   = p_next;
                  lo_in    = req_range_min;
                  hi_in    = req_range_max;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = rd_a * rd_b;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            scl_start = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            if (scl_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = prod_ff[31:1];
               rsp_ranged_in = scl_result;
               state_in      = ST_IDLE;
            end
         end
         ST_RESEED: begin
            mem_we    = seed_stat.wr_en;
            mem_waddr = seed_addr;
            mem_wdata = seed_data;
            if (seed_stat.done) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff       <= prod_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

   lpr_ring_ram #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re      (mem_re),
      .raddr_a (addr_a),
      .raddr_b (addr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   lpr_seeder #(
      .RING_DEPTH    (RING_DEPTH),
      .SHUFFLE_DEPTH (SHUFFLE_DEPTH),
      .AW            (AW)
   ) u_seeder (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (seed_ctrl),
      .stat    (seed_stat),
      .wr_addr (seed_addr),
      .wr_data (seed_data)
   );

   lpr_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .start     (scl_start),
      .raw       (prod_ff[31:1]),
      .range_min (lo_ff),
      .range_max (hi_ff),
      .done      (scl_done),
      .result    (scl_result)
   );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lpr_pkg::*;

   localparam int  DEPTH      = 2048;
   localparam int  LAG_LONG   = 1279;
   localparam int  LAG_SHORT  = 418;
   localparam int  TABLE_SIZE = 32;
   localparam longint MOD_A   = 64'd2147483563;
   localparam longint MOD_B   = 64'd2147483399;
   localparam longint SPREAD  = 1 + (MOD_A - 1) / TABLE_SIZE;
   localparam int  CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [30:0] raw;
      logic [31:0] ranged;
   } number_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [30:0] req_seed;
   logic [31:0] req_range_min;
   logic [31:0] req_range_max;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [30:0] rsp_raw_value;
   logic [31:0] rsp_ranged_value;

   // own copy of the generator state
   logic [31:0] ring [DEPTH];
   int          ring_ptr;
   longint      lcg_first;
   longint      lcg_second;
   longint      shuffle_out;
   longint      shuffle_table [TABLE_SIZE];

   number_type  pending_numbers [$];
   int          mismatch_count;
   int          cycle_count;
   int          sender_idle_pct;
   int          receiver_stall_pct;

   lagged_product_random_generator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_seed(req_seed),
      .req_range_min(req_range_min), .req_range_max(req_range_max),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_raw_value(rsp_raw_value), .rsp_ranged_value(rsp_ranged_value)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint lcg_next(longint x, longint a, longint q, longint r,
                                       longint m);
      longint k;
      longint y;
      k = x / q;
      y = a * (x - k * q) - k * r;
      if (y < 0) begin
         y += m;
      end
      return y;
   endfunction

   function automatic bit draw_bit();
      longint j;
      lcg_first  = lcg_next(lcg_first, 40014, 53668, 12211, MOD_A);
      lcg_second = lcg_next(lcg_second, 40692, 52774, 3791, MOD_B);
      j = shuffle_out / SPREAD;
      if (j < 0) begin
         j = 0;
      end
      if (j >= TABLE_SIZE) begin
         j = TABLE_SIZE - 1;
      end
      shuffle_out = shuffle_table[j] - lcg_second;
      shuffle_table[j] = lcg_first;
      if (shuffle_out < 1) begin
         shuffle_out += MOD_A - 1;
      end
      return 2 * shuffle_out > MOD_A;
   endfunction

   function automatic void refill_ring(logic [30:0] seed);
      longint      x;
      logic [31:0] word;
      x = seed;
      if (x < 1) begin
         x = 1;
      end
      lcg_second = x;
      for (int j = TABLE_SIZE + 7; j >= 0; j--) begin
         x = lcg_next(x, 40014, 53668, 12211, MOD_A);
         if (j < TABLE_SIZE) begin
            shuffle_table[j] = x;
         end
      end
      lcg_first = x;
      shuffle_out = shuffle_table[0];
      for (int w = 0; w < DEPTH; w++) begin
         word = '0;
         for (int b = 0; b < 32; b++) begin
            word[b] = draw_bit();
         end
         ring[w] = {word[30:0], 1'b1};
      end
      ring_ptr = 0;
   endfunction

   function automatic number_type next_number(logic [31:0] lo_bits, logic [31:0] hi_bits);
      number_type n;
      longint     lo;
      longint     hi;
      longint     val;
      ring_ptr = (ring_ptr + 1) % DEPTH;
      ring[ring_ptr] = ring[(ring_ptr + DEPTH - LAG_LONG) % DEPTH]
                     * ring[(ring_ptr + DEPTH - LAG_SHORT) % DEPTH];
      n.raw = ring[ring_ptr][31:1];
      lo = longint'($signed(lo_bits));
      hi = longint'($signed(hi_bits));
      if (hi < lo) begin
         val = lo;
      end else begin
         val = lo + (longint'(n.raw) * (hi - lo + 1)) / 64'd2147483647;
         if (val > hi) begin
            val = hi;
         end
      end
      n.ranged = val[31:0];
      return n;
   endfunction

   // one request: optional idle gap, then hold until accepted
   task automatic send_request(opcode_type op, logic [30:0] seed,
                               logic [31:0] lo, logic [31:0] hi);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_seed      <= seed;
      req_range_min <= lo;
      req_range_max <= hi;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (op == OP_RESEED) begin
         refill_ring(seed);
      end else begin
         pending_numbers.push_back(next_number(lo, hi));
      end
   endtask

   task automatic generate_in_range(logic [31:0] lo, logic [31:0] hi);
      send_request(OP_GENERATE, 31'($urandom), lo, hi);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_numbers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_directed();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // ring still zero before the first reseed
      generate_in_range(32'h8000_0000, 32'h7fff_ffff);
      generate_in_range(32'd0, 32'd0);
      generate_in_range(32'd5, 32'd3);
      generate_in_range(32'h7fff_ffff, 32'h8000_0000);
      // zero seed behaves as one
      send_request(OP_RESEED, 31'd0, 32'd0, 32'd0);
      generate_in_range(32'h8000_0000, 32'h7fff_ffff);
      generate_in_range(32'd0, 32'd0);
      generate_in_range(32'h7fff_ffff, 32'h7fff_ffff);
      generate_in_range(32'h8000_0000, 32'h8000_0000);
      generate_in_range(-32'sd10, 32'sd10);
      generate_in_range(32'd0, 32'h7fff_fffe);
      generate_in_range(32'd0, 32'h7fff_ffff);
      generate_in_range(32'hffff_ffff, 32'h8000_0000);
      generate_in_range(32'd1, 32'd0);
      generate_in_range(32'h8000_0000, 32'hffff_ffff);
      drain_results();
   endtask

   task automatic test_reseed_all_ones();
      send_request(OP_RESEED, 31'h7fff_ffff, $urandom, $urandom);
      generate_in_range(32'h8000_0000, 32'h7fff_ffff);
      drain_results();
   endtask

   task automatic test_random_generates(int idle_pct, int stall_pct, int count);
      logic [31:0] lo;
      logic [31:0] hi;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         lo = $urandom;
         case ($urandom_range(4))
            0: hi = $urandom;
            1: hi = lo + $urandom_range(1000);
            2: hi = lo;
            3: begin
               lo = $urandom_range(1) ? 32'h8000_0000 : $urandom_range(100);
               hi = $urandom_range(1) ? 32'h7fff_ffff : lo + $urandom_range(100000);
            end
            default: hi = lo - $urandom_range(1000);
         endcase
         generate_in_range(lo, hi);
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      number_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_numbers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result raw=%0d ranged=%0d", rsp_raw_value,
                        $signed(rsp_ranged_value));
            end
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_raw_value !== want.raw || rsp_ranged_value !== want.ranged) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch: raw exp %0d got %0d, ranged exp %0d got %0d",
                           want.raw, rsp_raw_value, $signed(want.ranged),
                           $signed(rsp_ranged_value));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      mismatch_count     = 0;
      cycle_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      ring_ptr           = 0;
      lcg_first          = 0;
      lcg_second         = 123456789;
      shuffle_out        = 0;
      for (int i = 0; i < DEPTH; i++) begin
         ring[i] = '0;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         shuffle_table[i] = 0;
      end
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_GENERATE;
      req_seed      = '0;
      req_range_min = '0;
      req_range_max = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_generates(0, 0, 200);
      test_random_generates(78, 0, 200);
      test_reseed_all_ones();
      test_random_generates(0, 78, 200);
      test_random_generates(26, 26, 200);

      repeat (30) @(posedge clock);
      mismatch_count += pending_numbers.size();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
